// ----- rtl/scalar_kalman_filter_top_assert.svh -----
// assertion macros for the scalar kalman filter
`ifndef SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define SKF_ASSERT_SAME(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/skf_pkg.sv -----
// shared types, constants and microcode table of the scalar kalman filter
`default_nettype none

package skf_pkg;

   // field widths
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int ERR_WIDTH        = 16;
   localparam int DEN_WIDTH        = 17;
   localparam int EST_FIELD_WIDTH  = 16;
   localparam int GAIN_FIELD_WIDTH = 17;
   localparam int RSP_TDATA_WIDTH  = 56;
   localparam int RSP_PAD_WIDTH    =
      RSP_TDATA_WIDTH - EST_FIELD_WIDTH - GAIN_FIELD_WIDTH - ERR_WIDTH;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_NOISE    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEASURE_NOISE    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_ERROR    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_ESTIMATE = 2'd3;

   // register reset values
   localparam logic [CSR_DATA_WIDTH-1:0] PROCESS_NOISE_RESET    = 16'd819;
   localparam logic [CSR_DATA_WIDTH-1:0] MEASURE_NOISE_RESET    = 16'd2458;
   localparam logic [CSR_DATA_WIDTH-1:0] INITIAL_ERROR_RESET    = 16'd4096;
   localparam logic [CSR_DATA_WIDTH-1:0] INITIAL_ESTIMATE_RESET = 16'd6400;

   // micro-operations
   localparam int OP_WIDTH = 4;
   localparam logic [OP_WIDTH-1:0] OP_ACCEPT     = 4'd0;
   localparam logic [OP_WIDTH-1:0] OP_PREDICT    = 4'd1;
   localparam logic [OP_WIDTH-1:0] OP_DIV_INIT   = 4'd2;
   localparam logic [OP_WIDTH-1:0] OP_DIV_STEP   = 4'd3;
   localparam logic [OP_WIDTH-1:0] OP_GAIN       = 4'd4;
   localparam logic [OP_WIDTH-1:0] OP_MUL_GAIN   = 4'd5;
   localparam logic [OP_WIDTH-1:0] OP_UPDATE_EST = 4'd6;
   localparam logic [OP_WIDTH-1:0] OP_OUTPUT     = 4'd7;
   localparam logic [OP_WIDTH-1:0] OP_NOP        = 4'd8;

   // jump conditions
   localparam int COND_WIDTH = 3;
   localparam logic [COND_WIDTH-1:0] COND_NONE     = 3'd0;
   localparam logic [COND_WIDTH-1:0] COND_ALWAYS   = 3'd1;
   localparam logic [COND_WIDTH-1:0] COND_NO_REQ   = 3'd2;
   localparam logic [COND_WIDTH-1:0] COND_DIV_MORE = 3'd3;
   localparam logic [COND_WIDTH-1:0] COND_OUT_BUSY = 3'd4;

   localparam int STEP_WIDTH = 4;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic [COND_WIDTH-1:0] cond;
      logic [STEP_WIDTH-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic                accept;
      logic                load_out;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic div_more;
      logic out_busy;
   } seq_status_type;

   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] process_noise;
      logic [CSR_DATA_WIDTH-1:0] measure_noise;
      logic [CSR_DATA_WIDTH-1:0] initial_error;
      logic [CSR_DATA_WIDTH-1:0] initial_estimate;
   } csr_type;

   typedef struct packed {
      logic [ERR_WIDTH-1:0]        error_covariance;
      logic [GAIN_FIELD_WIDTH-1:0] gain;
      logic [EST_FIELD_WIDTH-1:0]  estimate;
   } result_type;

   // microcode program, one control word per step
   function automatic ucode_type skf_micro_word(input logic [STEP_WIDTH-1:0] step);
      ucode_type w;
      case (step)
         4'd0:    w = '{op: OP_ACCEPT,     cond: COND_NO_REQ,   target: 4'd0};
         4'd1:    w = '{op: OP_PREDICT,    cond: COND_NONE,     target: 4'd0};
         4'd2:    w = '{op: OP_DIV_INIT,   cond: COND_NONE,     target: 4'd0};
         4'd3:    w = '{op: OP_DIV_STEP,   cond: COND_DIV_MORE, target: 4'd3};
         4'd4:    w = '{op: OP_GAIN,       cond: COND_NONE,     target: 4'd0};
         4'd5:    w = '{op: OP_MUL_GAIN,   cond: COND_NONE,     target: 4'd0};
         4'd6:    w = '{op: OP_UPDATE_EST, cond: COND_NONE,     target: 4'd0};
         4'd7:    w = '{op: OP_OUTPUT,     cond: COND_OUT_BUSY, target: 4'd7};
         4'd8:    w = '{op: OP_NOP,        cond: COND_ALWAYS,   target: 4'd0};
         default: w = '{op: OP_NOP,        cond: COND_ALWAYS,   target: 4'd0};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/skf_sequencer.sv -----
// step counter and microcode decode of the scalar kalman filter
`default_nettype none

module skf_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire skf_pkg::seq_status_type status,
   output skf_pkg::ctrl_type           ctrl
);
   import skf_pkg::*;

   logic [STEP_WIDTH-1:0] step_ff;
   logic [STEP_WIDTH-1:0] step_in;
   ucode_type             uword;
   logic                  jump;

   // fetch and branch
   always_comb begin
      uword = skf_micro_word(step_ff);
      case (uword.cond)
         COND_NONE:     jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = !status.req_valid;
         COND_DIV_MORE: jump = status.div_more;
         COND_OUT_BUSY: jump = status.out_busy;
         default:       jump = 1'b0;
      endcase
      step_in = jump ? uword.target : step_ff + 1'b1;
   end

   // control word to the datapath
   always_comb begin
      ctrl.op       = uword.op;
      ctrl.accept   = (uword.op == OP_ACCEPT) && status.req_valid;
      ctrl.load_out = (uword.op == OP_OUTPUT) && !status.out_busy;
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/skf_datapath.sv -----
// filter registers, shared divider step and shared multiplier
`default_nettype none
`include "scalar_kalman_filter_top_assert.svh"

module skf_datapath #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire skf_pkg::ctrl_type       ctrl,
   input  wire skf_pkg::csr_type        csr,
   input  wire logic [SAMPLE_WIDTH-1:0] sample,
   input  wire logic                    restart,
   output logic                         div_more,
   output skf_pkg::result_type          result
);
   import skf_pkg::*;

   localparam int EST_W      = (SAMPLE_WIDTH > EST_FIELD_WIDTH) ? SAMPLE_WIDTH : EST_FIELD_WIDTH;
   localparam int GAIN_W     = GAIN_FRAC_BITS + 1;
   localparam int GAIN_EXT_W = (GAIN_W > GAIN_FIELD_WIDTH) ? GAIN_W : GAIN_FIELD_WIDTH;
   localparam int MUL_B_W    = EST_W + 1;
   localparam int PROD_W     = GAIN_W + 1 + MUL_B_W;
   localparam int CNT_W      = $clog2(GAIN_FRAC_BITS + 1);
   localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
   localparam logic signed [EST_W+1:0] EST_MAX =
      {{(EST_W + 3 - SAMPLE_WIDTH){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [EST_W+1:0] EST_MIN = ~EST_MAX;

   // filter state
   logic signed [EST_W-1:0]        est_ff;
   logic [ERR_WIDTH-1:0]           err_ff;
   // per-item working registers
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic [ERR_WIDTH-1:0]           pred_ff;
   logic [DEN_WIDTH-1:0]           denom_ff;
   logic [DEN_WIDTH-1:0]           rem_ff;
   logic [GAIN_W-1:0]              quo_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic [GAIN_W-1:0]              gain_ff;
   logic signed [MUL_B_W-1:0]      diff_ff;
   logic signed [PROD_W-1:0]       mul_ff;

   logic [DEN_WIDTH-1:0]           pred_sum;
   logic [ERR_WIDTH-1:0]           pred_sat;
   logic [DEN_WIDTH-1:0]           denom_sum;
   logic                           quo_top;
   logic [DEN_WIDTH:0]             rem_shift;
   logic                           quo_bit;
   logic [GAIN_W-1:0]              gain_sel;
   logic signed [MUL_B_W-1:0]      sample_wide;
   logic signed [MUL_B_W-1:0]      est_wide;
   logic signed [GAIN_W:0]         mul_a;
   logic signed [MUL_B_W-1:0]      mul_b;
   logic signed [PROD_W-1:0]       product;
   logic signed [PROD_W-1:0]       prod_shift;
   logic signed [EST_W+1:0]        est_sum;
   logic signed [EST_W+1:0]        est_clamp;
   logic [ERR_WIDTH-1:0]           err_next;
   logic [GAIN_EXT_W-1:0]          gain_ext;

   // predicted error, saturating
   assign pred_sum = {1'b0, err_ff} + {1'b0, csr.process_noise};
   assign pred_sat = pred_sum[ERR_WIDTH] ? {ERR_WIDTH{1'b1}} : pred_sum[ERR_WIDTH-1:0];

   // gain denominator and leading quotient bit
   assign denom_sum = {1'b0, pred_ff} + {1'b0, csr.measure_noise};
   assign quo_top   = ({1'b0, pred_ff} >= denom_sum);

   // one restoring divide step
   assign rem_shift = {rem_ff, 1'b0};
   assign quo_bit   = (rem_shift >= {1'b0, denom_ff});
   assign div_more  = (cnt_ff != CNT_W'(1));

   // zero denominator gives zero gain, quotient never passes one otherwise
   assign gain_sel = (denom_ff == '0) ? '0 : ((quo_ff > GAIN_ONE) ? GAIN_ONE : quo_ff);

   assign sample_wide = MUL_B_W'(sample_ff);
   assign est_wide    = MUL_B_W'(est_ff);

   // shared multiplier: gain times difference, then (one - gain) times predicted
   always_comb begin
      if (ctrl.op == OP_MUL_GAIN) begin
         mul_a = signed'({1'b0, gain_ff});
         mul_b = diff_ff;
      end else begin
         mul_a = signed'({1'b0, GAIN_ONE - gain_ff});
         mul_b = signed'({{(MUL_B_W - ERR_WIDTH){1'b0}}, pred_ff});
      end
      product = mul_a * mul_b;
   end

   // estimate step, floor shift and clamp to the sample range
   assign prod_shift = mul_ff >>> GAIN_FRAC_BITS;
   assign est_sum    = (EST_W + 2)'(est_ff) + signed'(prod_shift[EST_W+1:0]);
   always_comb begin
      if (est_sum > EST_MAX) begin
         est_clamp = EST_MAX;
      end else if (est_sum < EST_MIN) begin
         est_clamp = EST_MIN;
      end else begin
         est_clamp = est_sum;
      end
   end

   assign err_next = mul_ff[GAIN_FRAC_BITS +: ERR_WIDTH];

   // result word
   assign gain_ext                = GAIN_EXT_W'(gain_ff);
   assign result.estimate         = est_ff[EST_FIELD_WIDTH-1:0];
   assign result.gain             = gain_ext[GAIN_FIELD_WIDTH-1:0];
   assign result.error_covariance = err_next;

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= EST_W'(signed'(INITIAL_ESTIMATE_RESET));
         err_ff <= INITIAL_ERROR_RESET;
      end else begin
         case (ctrl.op)
            OP_ACCEPT: begin
               if (ctrl.accept && restart) begin
                  est_ff <= EST_W'(signed'(csr.initial_estimate));
                  err_ff <= csr.initial_error;
               end
            end
            OP_UPDATE_EST: begin
               est_ff <= est_clamp[EST_W-1:0];
            end
            OP_OUTPUT: begin
               err_ff <= err_next;
            end
            default: begin
            end
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_ACCEPT: begin
            if (ctrl.accept) begin
               sample_ff <= sample;
            end
         end
         OP_PREDICT: begin
            pred_ff <= pred_sat;
         end
         OP_DIV_INIT: begin
            denom_ff <= denom_sum;
            rem_ff   <= {1'b0, pred_ff} - (quo_top ? denom_sum : '0);
            quo_ff   <= GAIN_W'(quo_top);
            cnt_ff   <= CNT_W'(GAIN_FRAC_BITS);
         end
         OP_DIV_STEP: begin
            rem_ff <= quo_bit ? DEN_WIDTH'(rem_shift - {1'b0, denom_ff})
                              : rem_shift[DEN_WIDTH-1:0];
            quo_ff <= {quo_ff[GAIN_W-2:0], quo_bit};
            cnt_ff <= cnt_ff - 1'b1;
         end
         OP_GAIN: begin
            gain_ff <= gain_sel;
            diff_ff <= sample_wide - est_wide;
         end
         OP_MUL_GAIN: begin
            mul_ff <= product;
         end
         OP_UPDATE_EST: begin
            mul_ff <= product;
         end
         default: begin
         end
      endcase
   end

   // checks
   `SKF_ASSERT_SAME(a_gain_le_one, clock, reset, ctrl.op == OP_MUL_GAIN,
      gain_ff <= GAIN_ONE, "gain above one")
   `SKF_ASSERT_SAME(a_rem_below_denom, clock, reset,
      ctrl.op == OP_DIV_STEP && denom_ff != '0, rem_ff < denom_ff,
      "divider remainder not below denominator")
   `SKF_ASSERT_NEXT(a_est_toward_sample, clock, reset, ctrl.op == OP_UPDATE_EST,
      (est_wide >= $past(est_wide) && est_wide <= $past(sample_wide)) ||
      (est_wide <= $past(est_wide) && est_wide >= $past(sample_wide)),
      "estimate left the span between old estimate and sample")
   `SKF_ASSERT_SAME(a_err_le_pred, clock, reset, ctrl.op == OP_OUTPUT,
      err_next <= pred_ff, "updated error above predicted error")

endmodule

`default_nettype wire

// ----- rtl/scalar_kalman_filter_top.sv -----
// Scalar Kalman filter: one sample word in, one estimate/gain/error word out.
// The microcode takes one sample at a time and accepts no new sample until the result word
// for the last one is loaded, which waits while the output register is held; the gain comes from the
// restoring divider that the microcode runs one quotient bit per step.
// Reset: synchronous, active high; the configuration registers return to their reset values, the
// filter state to the initial error and estimate, and the sequencer starts at the step that takes a sample.
`default_nettype none

module scalar_kalman_filter_top #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   // sample word
   input  wire logic                                         req_tvalid,
   output logic                                              req_tready,
   input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]    req_tdata,  // sample, zero fill
   input  wire logic                                         req_tuser,  // restart
   // result word
   output logic                                              rsp_tvalid,
   input  wire logic                                         rsp_tready,
   // estimate, gain, error_covariance, zero fill
   output logic [skf_pkg::RSP_TDATA_WIDTH-1:0]               rsp_tdata,
   // register writes
   input  wire logic                                         csr_wr_en,
   input  wire logic [skf_pkg::CSR_INDEX_WIDTH-1:0]          csr_index,
   input  wire logic [skf_pkg::CSR_DATA_WIDTH-1:0]           csr_wdata
);
   import skf_pkg::*;

   csr_type        csr_ff;
   logic           rsp_valid_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff;
   ctrl_type       ctrl;
   seq_status_type status;
   logic           div_more;
   result_type     result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.process_noise    <= PROCESS_NOISE_RESET;
         csr_ff.measure_noise    <= MEASURE_NOISE_RESET;
         csr_ff.initial_error    <= INITIAL_ERROR_RESET;
         csr_ff.initial_estimate <= INITIAL_ESTIMATE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PROCESS_NOISE:    csr_ff.process_noise    <= csr_wdata;
            CSR_MEASURE_NOISE:    csr_ff.measure_noise    <= csr_wdata;
            CSR_INITIAL_ERROR:    csr_ff.initial_error    <= csr_wdata;
            CSR_INITIAL_ESTIMATE: csr_ff.initial_estimate <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer status
   assign status.req_valid = req_tvalid;
   assign status.div_more  = div_more;
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;

   assign req_tready = (ctrl.op == OP_ACCEPT);

   skf_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   skf_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .csr      (csr_ff),
      .sample   (req_tdata[SAMPLE_WIDTH-1:0]),
      .restart  (req_tuser),
      .div_more (div_more),
      .result   (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         rsp_data_ff <= {{RSP_PAD_WIDTH{1'b0}}, result};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
